FILE: sv/mscw_pkg.sv
// ----------------------------------------------------------------------------
// mscw_pkg
// Types, codes and constants shared by the segment cutter window block.
// ----------------------------------------------------------------------------
package mscw_pkg;

    localparam logic [2:0] FUNC_AUDIO  = 3'd0;
    localparam logic [2:0] FUNC_KEY    = 3'd1;
    localparam logic [2:0] FUNC_VIDEO  = 3'd2;
    localparam logic [2:0] FUNC_CONFIG = 3'd3;
    localparam logic [2:0] FUNC_BEGIN  = 3'd4;
    localparam logic [2:0] FUNC_END    = 3'd5;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEG = 8'd1;

    localparam logic [15:0] TARGET_MIN  = 16'd1000;
    localparam logic [15:0] TARGET_INIT = 16'd1000;
    localparam logic [7:0]  MAX_SEG_INIT = 8'd5;
    localparam logic [15:0] DUR_MAX     = 16'hFFFF;

    localparam int KEY_ROUND = 500;
    localparam int KEY_STEP  = 3000;
    localparam int MS_PER_S  = 1000;
    localparam int KEY_STEPS = (65535 + KEY_ROUND) / KEY_STEP;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] frame_time;
    } evt_item_t;

    typedef struct packed {
        logic        segment_closed;
        logic [15:0] closed_duration;
        logic        resend_configs;
        logic [31:0] first_sequence;
        logic [8:0]  segment_count;
        logic [23:0] window_duration;
        logic [8:0]  evicted_count;
    } res_item_t;

    typedef enum logic {
        ALU_SUB = 1'b0,
        ALU_ADD = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] res;
        logic        carry;
    } alu_rsp_t;

    // whole seconds of (limit + 500) / 3000, returned in ms
    function automatic logic [14:0] key_floor_ms(input logic [15:0] limit);
        logic [16:0] biased;
        logic [4:0]  steps;
        biased = {1'b0, limit} + 17'(KEY_ROUND);
        steps  = '0;
        for (int j = 1; j <= KEY_STEPS; j++)
        begin
            if (biased >= 17'(KEY_STEP * j))
            begin
                steps = steps + 5'd1;
            end
        end
        return 15'(steps) * 15'(MS_PER_S);
    endfunction

endpackage

FILE: sv/mscw_ifs.sv
// ----------------------------------------------------------------------------
// mscw channel interfaces
// Valid/ready channels for events, results and register writes.
// ----------------------------------------------------------------------------
interface mscw_evt_if import mscw_pkg::*; ();
    logic      valid;
    logic      ready;
    evt_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mscw_res_if import mscw_pkg::*; ();
    logic      valid;
    logic      ready;
    res_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mscw_cfg_if import mscw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output idx, output wdata, input ready);
    modport sink   (input valid, input idx, input wdata, output ready);
endinterface

FILE: sv/mscw_alu.sv
// ----------------------------------------------------------------------------
// mscw_alu
// Shared 32-bit add/subtract unit; carry is the borrow on subtract.
// ----------------------------------------------------------------------------
module mscw_alu import mscw_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [32:0] sum;

    always_comb
    begin
        unique case (req.op)
            ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
        endcase
        rsp.res   = sum[31:0];
        rsp.carry = sum[32];
    end

endmodule

FILE: sv/media_segment_cutter_window.sv
// ----------------------------------------------------------------------------
// media_segment_cutter_window
// Decides live-stream segment cuts from timed frame events and keeps a
// sliding window of closed segment durations.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          transfer when
//  evt      in   func, frame_time                 evt.valid & evt.ready
//  res      out  closed, duration, window status  res.valid & res.ready
//  cfg      in   idx, wdata                       cfg.valid & cfg.ready
//
//  One event at a time through a sequencer around one shared add/sub unit.
//  Event path: EVAL, then DIFF and CMP as a frame needs; a cut or a close goes
//  on via RECORD, WRITE, BOUND and EV_CHK, with an EV_SUB per evicted segment.
//  max_segments write: BOUND and EV_CHK with an EV_SUB per eviction, no result.
//  evt and cfg are not ready until the sequencer is idle; a finished result
//  stalls in S_DONE while the output register is full. No clearing pass.
// ----------------------------------------------------------------------------
module media_segment_cutter_window import mscw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    mscw_evt_if.sink         evt,
    mscw_res_if.source       res,
    mscw_cfg_if.sink         cfg
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_EVAL   = 10'b00_0000_0010,
        S_DIFF   = 10'b00_0000_0100,
        S_CMP    = 10'b00_0000_1000,
        S_RECORD = 10'b00_0001_0000,
        S_EV_SUB = 10'b00_0010_0000,
        S_WRITE  = 10'b00_0100_0000,
        S_BOUND  = 10'b00_1000_0000,
        S_EV_CHK = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic        started_reg, started_next;
    logic        first_pend_reg, first_pend_next;
    logic        keying_reg, keying_next;
    logic        key_seen_reg, key_seen_next;
    logic [31:0] last_stamp_reg, last_stamp_next;
    logic [31:0] seg_start_reg, seg_start_next;
    logic [15:0] cut_limit_reg, cut_limit_next;
    logic [15:0] target_reg, target_next;
    logic [7:0]  max_seg_reg, max_seg_next;
    logic [AW-1:0] head_reg, head_next;
    logic [8:0]  count_reg, count_next;
    logic [23:0] total_reg, total_next;
    logic [31:0] oldest_reg, oldest_next;
    logic        closed_reg, closed_next;
    logic        resend_reg, resend_next;
    logic        key_event_reg, key_event_next;
    logic [8:0]  evicted_reg, evicted_next;
    logic        forced_reg, forced_next;
    logic        report_reg, report_next;
    logic        res_valid_reg, res_valid_next;

    logic [2:0]  func_reg, func_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] diff_reg, diff_next;
    logic [14:0] thresh_reg, thresh_next;
    logic [15:0] dur_reg, dur_next;
    logic [23:0] bound_reg, bound_next;
    res_item_t   res_data_reg, res_data_next;

    logic [15:0] mem [WINDOW_DEPTH];
    logic [15:0] rdata_reg;
    logic [AW-1:0] waddr;
    logic [9:0]  wsum;

    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;

    logic        evt_xfer;
    logic        cfg_xfer;
    logic [15:0] cfg_target;
    logic [15:0] dur_sat;
    logic        evict_cond;

    mscw_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign evt.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready = (state_reg == S_IDLE);
    assign evt_xfer  = evt.valid && evt.ready;
    assign cfg_xfer  = cfg.valid && cfg.ready;
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    assign cfg_target = (cfg.wdata < TARGET_MIN) ? TARGET_MIN : cfg.wdata;

    always_comb
    begin
        wsum = 10'(head_reg) + 10'(count_reg);
        if (wsum >= 10'(WINDOW_DEPTH))
        begin
            wsum = wsum - 10'(WINDOW_DEPTH);
        end
        waddr = wsum[AW-1:0];
    end

    // shared unit operand selection
    always_comb
    begin
        alu_req.op = ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (state_reg)
            S_EVAL:
            begin
                if (func_reg == FUNC_BEGIN || func_reg == FUNC_END)
                begin
                    alu_req.a = last_stamp_reg;
                    alu_req.b = seg_start_reg;
                end
                else
                begin
                    alu_req.a = stamp_reg;
                    alu_req.b = last_stamp_reg;
                end
            end
            S_DIFF:
            begin
                alu_req.a = stamp_reg;
                alu_req.b = seg_start_reg;
            end
            S_CMP:
            begin
                alu_req.a = diff_reg;
                alu_req.b = keying_reg ? 32'(thresh_reg) : 32'(cut_limit_reg);
            end
            S_EV_SUB:
            begin
                alu_req.a = 32'(total_reg);
                alu_req.b = 32'(rdata_reg);
            end
            S_WRITE:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = 32'(total_reg);
                alu_req.b  = 32'(dur_reg);
            end
            S_EV_CHK:
            begin
                alu_req.a = 32'(bound_reg);
                alu_req.b = 32'(total_reg);
            end
            default:
            begin
                alu_req.op = ALU_SUB;
            end
        endcase
    end

    assign dur_sat    = (diff_reg[31:16] != 16'd0) ? DUR_MAX : diff_reg[15:0];
    assign evict_cond = (count_reg != 9'd0)
                        && ((count_reg > (9'(max_seg_reg) + 9'd1)) || alu_rsp.carry);

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        first_pend_next = first_pend_reg;
        keying_next     = keying_reg;
        key_seen_next   = key_seen_reg;
        last_stamp_next = last_stamp_reg;
        seg_start_next  = seg_start_reg;
        cut_limit_next  = cut_limit_reg;
        target_next     = target_reg;
        max_seg_next    = max_seg_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        oldest_next     = oldest_reg;
        closed_next     = closed_reg;
        resend_next     = resend_reg;
        key_event_next  = key_event_reg;
        evicted_next    = evicted_reg;
        forced_next     = forced_reg;
        report_next     = report_reg;
        res_valid_next  = res_valid_reg;
        func_next       = func_reg;
        stamp_next      = stamp_reg;
        diff_next       = diff_reg;
        thresh_next     = thresh_reg;
        dur_next        = dur_reg;
        bound_next      = bound_reg;
        res_data_next   = res_data_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_xfer)
                begin
                    if (cfg.idx == REG_TARGET)
                    begin
                        target_next = cfg_target;
                        if (cfg_target > cut_limit_reg)
                        begin
                            cut_limit_next = cfg_target;
                        end
                    end
                    else if (cfg.idx == REG_MAX_SEG)
                    begin
                        max_seg_next = cfg.wdata[7:0];
                        report_next  = 1'b0;
                        forced_next  = 1'b0;
                        state_next   = S_BOUND;
                    end
                end
                else if (evt_xfer)
                begin
                    func_next      = evt.data.func;
                    stamp_next     = evt.data.frame_time;
                    closed_next    = 1'b0;
                    resend_next    = 1'b0;
                    key_event_next = 1'b0;
                    evicted_next   = '0;
                    forced_next    = 1'b0;
                    report_next    = 1'b1;
                    dur_next       = '0;
                    state_next     = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = S_DONE;
                priority if (func_reg == FUNC_BEGIN || func_reg == FUNC_END)
                begin
                    if (func_reg == FUNC_BEGIN)
                    begin
                        started_next    = 1'b1;
                        first_pend_next = 1'b1;
                        keying_next     = 1'b0;
                        key_seen_next   = 1'b0;
                    end
                    else
                    begin
                        started_next = 1'b0;
                    end
                    if (started_reg && !first_pend_reg)
                    begin
                        closed_next = 1'b1;
                        if (alu_rsp.res[31])
                        begin
                            dur_next = '0;
                        end
                        else if (alu_rsp.res[31:16] != 16'd0)
                        begin
                            dur_next = DUR_MAX;
                        end
                        else
                        begin
                            dur_next = alu_rsp.res[15:0];
                        end
                        state_next = S_RECORD;
                    end
                end
                else if (!started_reg || func_reg > FUNC_CONFIG)
                begin
                    state_next = S_DONE;
                end
                else if (func_reg == FUNC_CONFIG)
                begin
                    keying_next = 1'b0;
                end
                else if (func_reg == FUNC_KEY && keying_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    if (func_reg == FUNC_KEY)
                    begin
                        keying_next    = 1'b1;
                        resend_next    = 1'b1;
                        key_event_next = 1'b1;
                    end
                    else
                    begin
                        keying_next = 1'b0;
                    end
                    if (first_pend_reg)
                    begin
                        first_pend_next = 1'b0;
                        last_stamp_next = stamp_reg;
                        seg_start_next  = stamp_reg;
                    end
                    else
                    begin
                        if (alu_rsp.res != 32'd0 && !alu_rsp.res[31])
                        begin
                            last_stamp_next = stamp_reg;
                        end
                        state_next = S_DIFF;
                    end
                end
            end

            S_DIFF:
            begin
                diff_next   = alu_rsp.res;
                thresh_next = key_floor_ms(cut_limit_reg);
                state_next  = alu_rsp.res[31] ? S_DONE : S_CMP;
            end

            S_CMP:
            begin
                if ((keying_reg != key_seen_reg) || alu_rsp.carry)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    closed_next    = 1'b1;
                    resend_next    = 1'b1;
                    dur_next       = dur_sat;
                    seg_start_next = stamp_reg;
                    key_seen_next  = 1'b0;
                    if (dur_sat > cut_limit_reg)
                    begin
                        cut_limit_next = dur_sat;
                    end
                    state_next = S_RECORD;
                end
            end

            S_RECORD:
            begin
                if (count_reg == 9'(WINDOW_DEPTH))
                begin
                    forced_next = 1'b1;
                    state_next  = S_EV_SUB;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end

            S_EV_SUB:
            begin
                total_next   = alu_rsp.res[23:0];
                head_next    = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next   = count_reg - 9'd1;
                oldest_next  = oldest_reg + 32'd1;
                evicted_next = evicted_reg + 9'd1;
                forced_next  = 1'b0;
                state_next   = forced_reg ? S_WRITE : S_EV_CHK;
            end

            S_WRITE:
            begin
                count_next = count_reg + 9'd1;
                total_next = alu_rsp.res[23:0];
                state_next = S_BOUND;
            end

            S_BOUND:
            begin
                bound_next = 24'(max_seg_reg) * 24'(cut_limit_reg);
                state_next = S_EV_CHK;
            end

            S_EV_CHK:
            begin
                if (evict_cond)
                begin
                    state_next = S_EV_SUB;
                end
                else
                begin
                    state_next = report_reg ? S_DONE : S_IDLE;
                end
            end

            S_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next                = 1'b1;
                    res_data_next.segment_closed  = closed_reg;
                    res_data_next.closed_duration = closed_reg ? dur_reg : 16'd0;
                    res_data_next.resend_configs  = resend_reg;
                    res_data_next.first_sequence  = oldest_reg;
                    res_data_next.segment_count   = count_reg;
                    res_data_next.window_duration = total_reg;
                    res_data_next.evicted_count   = evicted_reg;
                    if (key_event_reg)
                    begin
                        key_seen_next = 1'b1;
                    end
                    if (func_reg == FUNC_BEGIN)
                    begin
                        cut_limit_next = target_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            started_reg    <= 1'b0;
            first_pend_reg <= 1'b1;
            keying_reg     <= 1'b0;
            key_seen_reg   <= 1'b0;
            last_stamp_reg <= '0;
            seg_start_reg  <= '0;
            cut_limit_reg  <= TARGET_INIT;
            target_reg     <= TARGET_INIT;
            max_seg_reg    <= MAX_SEG_INIT;
            head_reg       <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            oldest_reg     <= '0;
            closed_reg     <= 1'b0;
            resend_reg     <= 1'b0;
            key_event_reg  <= 1'b0;
            evicted_reg    <= '0;
            forced_reg     <= 1'b0;
            report_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            first_pend_reg <= first_pend_next;
            keying_reg     <= keying_next;
            key_seen_reg   <= key_seen_next;
            last_stamp_reg <= last_stamp_next;
            seg_start_reg  <= seg_start_next;
            cut_limit_reg  <= cut_limit_next;
            target_reg     <= target_next;
            max_seg_reg    <= max_seg_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            oldest_reg     <= oldest_next;
            closed_reg     <= closed_next;
            resend_reg     <= resend_next;
            key_event_reg  <= key_event_next;
            evicted_reg    <= evicted_next;
            forced_reg     <= forced_next;
            report_reg     <= report_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        stamp_reg    <= stamp_next;
        diff_reg     <= diff_next;
        thresh_reg   <= thresh_next;
        dur_reg      <= dur_next;
        bound_reg    <= bound_next;
        res_data_reg <= res_data_next;
    end

    // duration ring
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
        begin
            mem[waddr] <= dur_reg;
        end
        rdata_reg <= mem[head_reg];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 9'(WINDOW_DEPTH))
        else $error("window count above ring depth");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 9'd0) |-> (total_reg == 24'd0))
        else $error("empty window with nonzero total");

    a_evt_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        evt_xfer |=> (state_reg == S_EVAL))
        else $error("accepted event not evaluated");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> res_valid_reg)
        else $error("result not presented after completion");

endmodule
